@@ sv/bdr_pkg.sv @@
// ============================================================================
// bdr_pkg - shared definitions for the binomial divisibility run finder
// Field widths, register indexes, reset values and the small structs passed
// between the front end, the queue and the digit-test back end.
// ============================================================================
package bdr_pkg;

    // Fixed field and port widths
    localparam int FIELD_W     = 32;
    localparam int BASE_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    // Defaults for the top-level parameters
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIFO_DEPTH_DEF = 2;

    // Dividend bits retired per cycle by the digit divider
    localparam int DIGIT_STEP = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_P = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_M  = 8'd1;

    // Base reset value and smallest usable base
    localparam logic [BASE_W-1:0] BASE_P_RESET = 8'd2;
    localparam logic [BASE_W-1:0] MIN_BASE     = 8'd2;

    // Classification of an accepted word
    typedef struct packed {
        logic is_one;
        logic is_top;
    } bdr_class_t;

    // Result of one digit test
    typedef struct packed {
        logic done;
        logic hit;
    } bdr_digit_res_t;

    // Working width of values: the field width, or less if the value width is narrower
    function automatic int eff_width(input int value_bits);
        return (value_bits < FIELD_W) ? value_bits : FIELD_W;
    endfunction

endpackage

@@ sv/bdr_fifo.sv @@
// ============================================================================
// bdr_fifo - short queue between front end and back end
// Register-based first-in first-out buffer; lets either side stall on its own.
// ============================================================================
module bdr_fifo
    import bdr_pkg::*;
#(
    parameter int WIDTH = 34,
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

@@ sv/bdr_front.sv @@
// ============================================================================
// bdr_front - input acceptance and classification
// Masks the candidate to the working width, flags the run-clearing value one
// and the closing value top_m, and pushes the word into the queue.
// ============================================================================
module bdr_front
    import bdr_pkg::*;
#(
    parameter int EW = 32
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,     // [31:0] x_value
    input  logic [EW-1:0]         top_m,
    output logic                  push,
    output logic [EW-1:0]         push_x,
    output bdr_class_t            push_class,
    input  logic                  full
);

    // Accept whenever the queue has room
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    // Mask and classify
    assign push_x            = s_tdata[EW-1:0];
    assign push_class.is_one = (s_tdata[EW-1:0] == EW'(1));
    assign push_class.is_top = (s_tdata[EW-1:0] == top_m);

endmodule

@@ sv/bdr_digit.sv @@
// ============================================================================
// bdr_digit - iterative base-p digit comparator
// Divides x and m by p in lockstep, DIGIT_STEP dividend bits per cycle, and
// compares the remainders digit by digit, lowest first, stopping early.
// ============================================================================
module bdr_digit
    import bdr_pkg::*;
#(
    parameter int EW = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [BASE_W-1:0] p,
    input  logic [EW-1:0]     a0,
    input  logic [EW-1:0]     b0,
    output bdr_digit_res_t    res
);

    localparam int DW     = ((EW + DIGIT_STEP - 1) / DIGIT_STEP) * DIGIT_STEP;
    localparam int NCHUNK = DW / DIGIT_STEP;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCHUNK - 1);

    localparam logic D_IDLE = 1'b0;
    localparam logic D_DIV  = 1'b1;

    logic              state_reg, state_next;
    logic [DW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [BASE_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [BASE_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next, hit_reg, hit_next;
    logic [DW-1:0]     qa, qb;
    logic [BASE_W-1:0] ra_c, rb_c;

    // Long division of one chunk: returns {remainder, shifted dividend/quotient}
    function automatic logic [DW+BASE_W-1:0] div_chunk(
        input logic [DW-1:0]     sh_in,
        input logic [BASE_W-1:0] r_in,
        input logic [BASE_W-1:0] d
    );
        logic [DW-1:0]   sh;
        logic [BASE_W:0] r;
        sh = sh_in;
        r  = {1'b0, r_in};
        for (int i = 0; i < DIGIT_STEP; i++) begin
            r  = {r[BASE_W-1:0], sh[DW-1]};
            sh = {sh[DW-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r     = r - {1'b0, d};
                sh[0] = 1'b1;
            end
        end
        return {r[BASE_W-1:0], sh};
    endfunction

    assign {ra_c, qa} = div_chunk(a_reg, ra_reg, p_reg);
    assign {rb_c, qb} = div_chunk(b_reg, rb_reg, p_reg);

    assign res.done = done_reg;
    assign res.hit  = hit_reg;

    // Sequence digit extraction and early exit
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    if (a0 == '0) begin
                        done_next = 1'b1;
                        hit_next  = 1'b0;
                    end else if (b0 == '0) begin
                        done_next = 1'b1;
                        hit_next  = 1'b1;
                    end else begin
                        a_next     = DW'(a0);
                        b_next     = DW'(b0);
                        ra_next    = '0;
                        rb_next    = '0;
                        p_next     = p;
                        cnt_next   = '0;
                        state_next = D_DIV;
                    end
                end
            end
            D_DIV: begin
                a_next   = qa;
                b_next   = qb;
                ra_next  = ra_c;
                rb_next  = rb_c;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next = '0;
                    ra_next  = '0;
                    rb_next  = '0;
                    if (ra_c > rb_c) begin
                        done_next  = 1'b1;
                        hit_next   = 1'b1;
                        state_next = D_IDLE;
                    end else if (qa == '0) begin
                        done_next  = 1'b1;
                        hit_next   = 1'b0;
                        state_next = D_IDLE;
                    end else if (qb == '0) begin
                        done_next  = 1'b1;
                        hit_next   = 1'b1;
                        state_next = D_IDLE;
                    end
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        hit_reg <= hit_next;
    end

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == D_IDLE && !done_reg))
        else $error("digit test started while busy");

endmodule

@@ sv/bdr_back.sv @@
// ============================================================================
// bdr_back - digit test and run tracking
// Takes one classified word at a time from the queue, runs the digit test,
// updates the open run and places finished runs in the output register.
// ============================================================================
module bdr_back
    import bdr_pkg::*;
#(
    parameter int EW = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   empty,
    output logic                   pop,
    input  logic [EW-1:0]          pop_x,
    input  bdr_class_t             pop_class,
    input  logic [BASE_W-1:0]      base_p,
    input  logic [EW-1:0]          top_m,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] run_first, [63:32] run_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_TEST = 2'd1;
    localparam logic [1:0] B_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [EW-1:0]     x_reg;
    bdr_class_t        cls_reg;
    logic              hit_reg;
    logic              in_run_reg, in_run_next;
    logic [EW-1:0]     run_begin_reg, run_begin_next;
    logic              m_valid_reg;
    logic [EW-1:0]     m_first_reg, m_last_reg;
    logic [BASE_W-1:0] p_eff;
    bdr_digit_res_t    res;
    logic              fin_go;
    logic              emit;
    logic              in_run_cur;
    logic [EW-1:0]     begin_cur;
    logic [EW-1:0]     out_first, out_last;

    // Bases below two behave as two
    assign p_eff = (base_p < MIN_BASE) ? MIN_BASE : base_p;

    assign pop    = (state_reg == B_IDLE) && !empty;
    assign fin_go = (state_reg == B_FIN) && (!m_valid_reg || m_tready);

    bdr_digit #(
        .EW (EW)
    ) u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pop),
        .p       (p_eff),
        .a0      (pop_x),
        .b0      (top_m),
        .res     (res)
    );

    // Sequence one word at a time
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (pop) state_next = B_TEST;
            B_TEST: if (res.done) state_next = B_FIN;
            B_FIN:  if (fin_go) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Update the open run; close it on a miss or at top_m
    always_comb begin
        in_run_cur     = cls_reg.is_one ? 1'b0 : in_run_reg;
        begin_cur      = cls_reg.is_one ? '0 : run_begin_reg;
        emit           = 1'b0;
        out_first      = begin_cur;
        out_last       = x_reg - EW'(1);
        in_run_next    = in_run_cur;
        run_begin_next = begin_cur;
        if (hit_reg && !in_run_cur) begin
            in_run_next    = 1'b1;
            run_begin_next = x_reg;
        end else if (!hit_reg && in_run_cur) begin
            emit        = 1'b1;
            in_run_next = 1'b0;
        end
        if (cls_reg.is_top) begin
            if (in_run_next && !emit) begin
                emit      = 1'b1;
                out_first = run_begin_next;
                out_last  = x_reg;
            end
            in_run_next    = 1'b0;
            run_begin_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            in_run_reg    <= 1'b0;
            run_begin_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_go) begin
                in_run_reg    <= in_run_next;
                run_begin_reg <= run_begin_next;
            end
            if (fin_go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the word under test and the finished pair
    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg   <= pop_x;
            cls_reg <= pop_class;
        end
        if (res.done) begin
            hit_reg <= res.hit;
        end
        if (fin_go && emit) begin
            m_first_reg <= out_first;
            m_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {FIELD_W'(m_last_reg), FIELD_W'(m_first_reg)};

    a_done_in_test: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> (state_reg == B_TEST))
        else $error("digit result arrived outside the test state");

    a_fin_after_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_TEST && res.done) |=> (state_reg == B_FIN))
        else $error("test result not taken into the finish state");

endmodule

@@ sv/binomial_divisibility_runs_core.sv @@
// ============================================================================
// binomial_divisibility_runs_core - runs of x where p divides C(m, x)
// Each candidate x is a hit when some base-p digit of x exceeds the matching
// digit of top_m; maximal runs of hits leave as (run_first, run_last) pairs.
// Each item is tested by the digit divider, which retires eight dividend bits per
// cycle for x and top_m in lockstep and examines base-p digit positions until a
// hit is found or the digits of x run out (at most 32 positions, for base 2). Items
// queue in a short buffer in front of the divider, and a finished pair waits in
// the output register while the next item is tested. x equal to one clears the
// run state; x equal to top_m closes any open run at top_m. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
// ============================================================================
module binomial_divisibility_runs_core
    import bdr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [31:0] x_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [31:0] run_first, [63:32] run_last
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int EW = eff_width(VALUE_BITS);
    localparam int QW = EW + $bits(bdr_class_t);

    logic [BASE_W-1:0] base_p_reg;
    logic [EW-1:0]     top_m_reg;
    logic              push, full, pop, empty;
    logic [EW-1:0]     push_x, pop_x;
    bdr_class_t        push_class, pop_class;
    logic [QW-1:0]     pop_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_p_reg <= BASE_P_RESET;
            top_m_reg  <= EW'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_P: base_p_reg <= cfg_wdata[BASE_W-1:0];
                REG_TOP_M:  top_m_reg  <= cfg_wdata[EW-1:0];
                default: ;
            endcase
        end
    end

    bdr_front #(
        .EW (EW)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .top_m      (top_m_reg),
        .push       (push),
        .push_x     (push_x),
        .push_class (push_class),
        .full       (full)
    );

    bdr_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_class, push_x}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    assign {pop_class, pop_x} = pop_data;

    bdr_back #(
        .EW (EW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop       (pop),
        .pop_x     (pop_x),
        .pop_class (pop_class),
        .base_p    (base_p_reg),
        .top_m     (top_m_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/binomial_divisibility_runs_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// binomial_divisibility_runs_core_tb - regression for the binomial run finder
// Scans rows of x from 1 up to top_m under many bases. Each row is mostly
// well formed, with stray, repeated and out-of-range words mixed in. A
// scoreboard class predicts every (run_first, run_last) pair from its own copy
// of the registers and run state, and checks the pairs that the core emits.
// ============================================================================
module binomial_divisibility_runs_core_tb;
    import bdr_pkg::*;

    localparam int     SETTLE_CYCLES = 600;     // queue, divider and output register
    localparam int     TOTAL_WORDS   = 550;
    localparam int     QUIET_FROM    = 480;     // no idling from this word on
    localparam longint CYCLE_LIMIT   = 400000;
    localparam int     REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Predicts run pairs and checks the pairs seen on the result stream
    // ------------------------------------------------------------------------
    class run_pair_scoreboard;
        logic [BASE_W-1:0]  base_reg;
        logic [FIELD_W-1:0] top_reg;
        bit                 run_open;
        logic [FIELD_W-1:0] run_start;
        logic [63:0]        pairs_due[$];    // {run_last, run_first}
        int unsigned        fails;

        function new();
            base_reg  = BASE_P_RESET;
            top_reg   = 32'd1;
            run_open  = 1'b0;
            run_start = '0;
            fails     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_BASE_P)
                base_reg = val[BASE_W-1:0];
            else if (idx == REG_TOP_M)
                top_reg = val[FIELD_W-1:0];
        endfunction

        // Append a predicted pair at the tail of the queue
        function void queue_pair(logic [63:0] pair);
            pairs_due.insert(pairs_due.size(), pair);
        endfunction

        // True when some base-p digit of x exceeds the matching digit of m
        function bit digit_over(logic [31:0] p, logic [31:0] m, logic [31:0] x);
            logic [31:0] a;
            logic [31:0] b;
            a = x;
            b = m;
            while (a != 0 || b != 0) begin
                if (a % p > b % p)
                    return 1'b1;
                a = a / p;
                b = b / p;
            end
            return 1'b0;
        endfunction

        // Advance the run state by one accepted word
        function void note_word(logic [FIELD_W-1:0] x);
            logic [31:0] p;
            bit          hit;
            bit          emitted;
            p = (base_reg < MIN_BASE) ? 32'd2 : {24'd0, base_reg};
            emitted = 1'b0;
            if (x == 32'd1) begin
                run_open  = 1'b0;
                run_start = '0;
            end
            hit = digit_over(p, top_reg, x);
            if (hit && !run_open) begin
                run_open  = 1'b1;
                run_start = x;
            end else if (!hit && run_open) begin
                queue_pair({x - 32'd1, run_start});
                emitted  = 1'b1;
                run_open = 1'b0;
            end
            // top_m closes whatever is still open
            if (x == top_reg) begin
                if (run_open && !emitted)
                    queue_pair({top_reg, run_start});
                run_open  = 1'b0;
                run_start = '0;
            end
        endfunction

        function void check_pair(logic [OUT_TDATA_W-1:0] got);
            logic [63:0] want;
            if (pairs_due.size() == 0) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: unexpected pair first=%h last=%h",
                             $realtime, got[31:0], got[63:32]);
                return;
            end
            want = pairs_due.pop_front();
            if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32]) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: pair mismatch, expected first=%h last=%h, got first=%h last=%h",
                             $realtime, want[31:0], want[63:32], got[31:0], got[63:32]);
            end
        endfunction

        function int unsigned outstanding();
            return pairs_due.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // [31:0] x_value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [31:0] run_first, [63:32] run_last
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_BASE_P;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    run_pair_scoreboard sb;
    int unsigned        words_sent = 0;
    bit                 quiet      = 1'b0;
    bit                 tx_calm    = 1'b0;
    bit                 rx_calm    = 1'b0;
    int unsigned        hold_left  = 0;
    longint             cycles     = 0;

    binomial_divisibility_runs_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Check accepted pairs, and stall the result side in bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pair(m_tdata);
        if (hold_left != 0)
            hold_left--;
        else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0)
            hold_left = $urandom_range(1, 7);
        m_tready <= (hold_left == 0);
    end

    // Give up on a hung core
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("binomial_divisibility_runs_core regression: fail");
            $finish;
        end
    end

    // Offer one word, with an occasional gap ahead of it
    task automatic send_word(input logic [FIELD_W-1:0] x);
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(x);
        words_sent++;
        if (words_sent >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    // Hold the input until every predicted pair has left, then optionally settle
    task automatic drain(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers on back-to-back edges
    task automatic configure(input logic [BASE_W-1:0] base, input logic [FIELD_W-1:0] m);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BASE_P;
        cfg_wdata <= {24'd0, base};
        @(posedge aclk);
        cfg_index <= REG_TOP_M;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(REG_BASE_P, {24'd0, base});
        sb.write_reg(REG_TOP_M, m);
    endtask

    // One row: a scan of 1..m with noise, or the tail of a huge row
    task automatic scan_row(input logic [BASE_W-1:0] base, input logic [FIELD_W-1:0] m);
        int unsigned r;
        int          tail;
        drain(1'b1);
        configure(base, m);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        if (m > 64) begin
            send_word(32'd1);
            tail = $urandom_range(1, 12);
            for (int k = tail; k >= 0; k--)
                send_word(m - k);
        end else begin
            for (int unsigned x = 1; x <= m; x++) begin
                r = $urandom_range(0, 24);
                if (r == 0)
                    send_word($urandom);
                else if (r == 1)
                    send_word(m + $urandom_range(1, 5));
                else if (r == 2)
                    send_word(32'd0);
                else if (r == 3 && x > 2) begin
                    // restart the scan part way through
                    send_word(32'd1);
                    x = 1;
                end else
                    send_word(x);
                if (!quiet && $urandom_range(0, 39) == 0)
                    drain(1'b0);
            end
        end
    endtask

    initial begin
        logic [BASE_W-1:0]  primes [10];
        logic [BASE_W-1:0]  base;
        logic [FIELD_W-1:0] m;
        logic [3:0]         pick;
        primes = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd31, 8'd127, 8'd251};
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: open a run, clear it with one, close with a zero word
        send_word(32'd2);
        send_word(32'd3);
        send_word(32'd1);
        send_word(32'd2);
        send_word(32'd0);

        // Base zero behaves as two over a full scan
        drain(1'b1);
        configure(8'd0, 32'd10);
        for (int unsigned x = 1; x <= 10; x++)
            send_word(x);

        // Base one, largest top_m, extreme words
        drain(1'b1);
        configure(8'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'hFFFF_FFFE);

        // Largest base, words beyond top_m and out of order
        drain(1'b1);
        configure(8'd255, 32'h1234_5678);
        send_word(32'd1);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE);
        send_word(32'h1234_5678);

        // Random rows
        while (words_sent < TOTAL_WORDS) begin
            if ($urandom_range(0, 5) != 0) begin
                pick = 4'($urandom_range(0, 9));
                base = primes[pick];
            end else
                base = BASE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                m = $urandom_range(32'hFFFF_FFFF, 65);
            else
                m = $urandom_range(1, 40);
            scan_row(base, m);
        end

        drain(1'b1);
        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("binomial_divisibility_runs_core regression: pass");
        else
            $display("binomial_divisibility_runs_core regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bdr_pkg.sv
sv/bdr_fifo.sv
sv/bdr_front.sv
sv/bdr_digit.sv
sv/bdr_back.sv
sv/binomial_divisibility_runs_core.sv
tb/binomial_divisibility_runs_core_tb.sv
